// ===== rtl/core/lzwc_pkg.sv =====
package lzwc_pkg;

    localparam int WINDOW_DEPTH = 4096;
    localparam int ADDR_W       = $clog2(WINDOW_DEPTH);

    localparam int BYTE_W = 8;
    localparam int DIST_W = 12;
    localparam int LEN_W  = 4;

    // s_tdata layout, lowest bit first
    localparam int LIT_LSB  = 0;
    localparam int DIST_LSB = LIT_LSB + BYTE_W;
    localparam int LEN_LSB  = DIST_LSB + DIST_W;
    localparam int IN_W     = LEN_LSB + LEN_W;

    localparam logic CMD_LITERAL = 1'b0;
    localparam logic CMD_COPY    = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_FETCH
    } lzwc_state_t;

endpackage

// ===== rtl/core/lzwc_ram.sv =====
module lzwc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/core/lz_window_copy_decoder.sv =====
// LZSS window copy decoder. Takes one token per word on the slave side:
// s_tuser is the command (0 literal, 1 copy), s_tdata carries the literal
// byte, a 12-bit back distance and a 4-bit copy length. A literal gives one
// output word; a copy gives one word per byte, read distance bytes behind
// the newest one in a 4096-byte circular history held in a single
// one-write one-read RAM, so overlapping copies repeat recent bytes. A zero
// length copy gives nothing. m_tlast marks the final word of every token.
// A copy holds s_tready low until its last byte is loaded, since each byte
// needs a RAM read and then its write back before the next read may see it;
// output back-pressure (m_tready low with a word held) stalls either token.
// The history needs no clearing after reset; copies may only reach bytes
// already written.
module lz_window_copy_decoder
    import lzwc_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,

    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [IN_W-1:0]   s_tdata,   // literal_byte, back_distance, copy_length
    input  logic              s_tuser,   // command

    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [BYTE_W-1:0] m_tdata,   // data_byte
    output logic              m_tlast
);

    lzwc_state_t       state_reg, state_next;
    logic [ADDR_W-1:0] wp_reg, wp_next;
    logic [ADDR_W-1:0] dist_reg, dist_next;
    logic [LEN_W-1:0]  remain_reg, remain_next;

    logic              out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0] out_data_reg, out_data_next;
    logic              out_last_reg, out_last_next;

    logic              can_load;
    logic              load;
    logic [BYTE_W-1:0] load_data;
    logic              load_last;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_raddr;
    logic [BYTE_W-1:0] ram_rdata;

    logic [BYTE_W-1:0] in_lit;
    logic [DIST_W-1:0] in_dist;
    logic [LEN_W-1:0]  in_len;
    logic              in_fire;

    assign in_lit  = s_tdata[LIT_LSB  +: BYTE_W];
    assign in_dist = s_tdata[DIST_LSB +: DIST_W];
    assign in_len  = s_tdata[LEN_LSB  +: LEN_W];

    assign can_load = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) && can_load;
    assign in_fire  = s_tvalid && s_tready;

    assign ram_raddr = ADDR_W'(wp_reg - dist_reg - 1'b1);

    lzwc_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (WINDOW_DEPTH)
    ) u_history (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (wp_reg),
        .wdata (load_data),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            wp_reg        <= '0;
            remain_reg    <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            wp_reg        <= wp_next;
            remain_reg    <= remain_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        dist_reg     <= dist_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
    end

    always_comb begin
        state_next  = state_reg;
        dist_next   = dist_reg;
        remain_next = remain_reg;
        load        = 1'b0;
        load_data   = in_lit;
        load_last   = 1'b1;

        case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    if (s_tuser == CMD_LITERAL) begin
                        load = 1'b1;
                    end else if (in_len != '0) begin
                        dist_next   = ADDR_W'(in_dist);
                        remain_next = in_len;
                        state_next  = ST_READ;
                    end
                end
            end
            ST_READ: begin
                state_next = ST_FETCH;
            end
            ST_FETCH: begin
                load_data = ram_rdata;
                load_last = (remain_reg == LEN_W'(1));
                if (can_load) begin
                    load        = 1'b1;
                    remain_next = remain_reg - 1'b1;
                    state_next  = load_last ? ST_IDLE : ST_READ;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign ram_we  = load;
    assign wp_next = load ? ADDR_W'(wp_reg + 1'b1) : wp_reg;

    always_comb begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        if (load) begin
            out_valid_next = 1'b1;
            out_data_next  = load_data;
            out_last_next  = load_last;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

    // busy copy always has bytes left to produce
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != ST_IDLE |-> remain_reg != '0)
        else $error("copy in progress with no bytes left");

    // a literal word shows up next cycle as a single last word
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire && s_tuser == CMD_LITERAL |=> m_tvalid && m_tlast)
        else $error("literal did not produce a last word");

    // history pointer advances by one per byte written
    assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |=> wp_reg == ADDR_W'($past(wp_reg) + 1'b1))
        else $error("write pointer out of step with history writes");

endmodule

// ===== bench/lz_window_copy_decoder_tb.sv =====
`timescale 1ns / 1ps

module lz_window_copy_decoder_tb;
    import lzwc_pkg::*;

    localparam int WATCHDOG_CYCLES = 2000;
    localparam int TAIL_CYCLES     = 64;
    localparam int IDLE_PCT        = 18;

    typedef enum logic [1:0] {
        EXP_MODEL,
        EXP_NONE,
        EXP_BYTE
    } exp_kind_t;

    typedef struct packed {
        logic              cmd;
        logic [BYTE_W-1:0] lit;
        logic [DIST_W-1:0] back_dist;
        logic [LEN_W-1:0]  len;
        exp_kind_t         kind;
        logic [BYTE_W-1:0] exp_byte;
    } token_t;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
    } out_word_t;

    logic              aclk     = 1'b0;
    logic              aresetn  = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [IN_W-1:0]   s_tdata  = '0;
    logic              s_tuser  = CMD_LITERAL;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [BYTE_W-1:0] m_tdata;
    logic              m_tlast;

    logic [BYTE_W-1:0] hist_mem [WINDOW_DEPTH];
    logic [ADDR_W-1:0] wr_pos    = '0;
    int                hist_fill = 0;

    out_word_t decoded_q [$];
    token_t    drv_tok;
    bit        calm        = 1'b0;
    int        mismatches  = 0;
    int        idle_cycles = 0;
    int        n_random    = 0;

    // literal rows and zero length copies carry their result; the rest go by prediction
    token_t directed_tokens [15] = '{
        '{CMD_COPY,    8'h00, 12'h000, 4'h0, EXP_NONE,  8'h00},
        '{CMD_LITERAL, 8'h00, 12'h000, 4'h0, EXP_BYTE,  8'h00},
        '{CMD_LITERAL, 8'hFF, 12'hFFF, 4'hF, EXP_BYTE,  8'hFF},
        '{CMD_LITERAL, 8'hA5, 12'h5A5, 4'h5, EXP_BYTE,  8'hA5},
        '{CMD_LITERAL, 8'h5A, 12'hA5A, 4'hA, EXP_BYTE,  8'h5A},
        '{CMD_COPY,    8'h00, 12'h000, 4'h1, EXP_MODEL, 8'h00},
        '{CMD_COPY,    8'hFF, 12'h000, 4'hF, EXP_MODEL, 8'h00},
        '{CMD_COPY,    8'h00, 12'h003, 4'h4, EXP_MODEL, 8'h00},
        '{CMD_LITERAL, 8'h80, 12'hFFF, 4'hF, EXP_BYTE,  8'h80},
        '{CMD_COPY,    8'h00, 12'h018, 4'hF, EXP_MODEL, 8'h00},
        '{CMD_COPY,    8'hFF, 12'h027, 4'h0, EXP_NONE,  8'h00},
        '{CMD_COPY,    8'hFF, 12'h027, 4'hF, EXP_MODEL, 8'h00},
        '{CMD_LITERAL, 8'h7F, 12'h000, 4'h0, EXP_BYTE,  8'h7F},
        '{CMD_COPY,    8'h00, 12'h001, 4'h2, EXP_MODEL, 8'h00},
        '{CMD_COPY,    8'h00, 12'h001, 4'h8, EXP_MODEL, 8'h00}
    };

    lz_window_copy_decoder i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // updates the history copy and queues the words the token should produce
    task automatic decode_token(input token_t t);
        logic [ADDR_W-1:0] src;
        logic [BYTE_W-1:0] b;
        if (t.cmd == CMD_LITERAL) begin
            hist_mem[wr_pos] = t.lit;
            wr_pos = wr_pos + 1'b1;
            if (hist_fill < WINDOW_DEPTH) hist_fill++;
            if (t.kind == EXP_MODEL) decoded_q.push_back('{t.lit, 1'b1});
        end else begin
            for (int k = 0; k < t.len; k++) begin
                src = ADDR_W'(wr_pos - 1'b1 - t.back_dist);
                b = hist_mem[src];
                hist_mem[wr_pos] = b;
                wr_pos = wr_pos + 1'b1;
                if (hist_fill < WINDOW_DEPTH) hist_fill++;
                if (t.kind == EXP_MODEL) decoded_q.push_back('{b, k == t.len - 1});
            end
        end
        if (t.kind == EXP_BYTE) decoded_q.push_back('{t.exp_byte, 1'b1});
    endtask

    // copies only reach bytes already written; long copies favoured
    function automatic token_t random_token();
        token_t t;
        int span;
        int near;
        t.cmd       = ($urandom_range(99) < 15) ? CMD_LITERAL : CMD_COPY;
        t.lit       = BYTE_W'($urandom);
        t.back_dist = DIST_W'($urandom);
        t.len       = LEN_W'($urandom);
        t.kind      = EXP_MODEL;
        t.exp_byte  = '0;
        if (t.cmd == CMD_COPY) begin
            span = (hist_fill < WINDOW_DEPTH) ? hist_fill : WINDOW_DEPTH;
            near = (span > 16) ? 15 : span - 1;
            case ($urandom_range(3))
                0: t.back_dist = DIST_W'($urandom_range(near));
                1: t.back_dist = DIST_W'(span - 1);
                2: t.back_dist = DIST_W'(span - 1 - int'($urandom_range(near)));
                default: t.back_dist = DIST_W'($urandom_range(span - 1));
            endcase
            if ($urandom_range(3) != 0) t.len = LEN_W'($urandom_range(15, 11));
        end
        return t;
    endfunction

    task automatic send_token(input token_t t);
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        drv_tok = t;
        s_tvalid <= 1'b1;
        s_tuser  <= t.cmd;
        s_tdata  <= {t.len, t.back_dist, t.lit};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    always @(negedge aclk) begin
        m_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end

    always @(posedge aclk) begin
        out_word_t want;
        bit s_acc;
        bit m_acc;
        s_acc = aresetn && s_tvalid && s_tready;
        m_acc = aresetn && m_tvalid && m_tready;
        if (s_acc) decode_token(drv_tok);
        if (m_acc) begin
            if (decoded_q.size() == 0) begin
                $display("%0t: unexpected word: data %02h last %0b", $time, m_tdata, m_tlast);
                mismatches++;
            end else begin
                want = decoded_q.pop_front();
                if (m_tdata !== want.data || m_tlast !== want.last) begin
                    $display("%0t: word mismatch: expected data %02h last %0b, got data %02h last %0b",
                             $time, want.data, want.last, m_tdata, m_tlast);
                    mismatches++;
                end
            end
        end
        idle_cycles = (s_acc || m_acc) ? 0 : idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_CYCLES) begin
            $display("%0t: watchdog expired, %0d words outstanding", $time, decoded_q.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (directed_tokens[i]) send_token(directed_tokens[i]);

        // random tokens after the directed rows, about 120 in all
        while (n_random < 105) begin
            calm = (n_random >= 40 && n_random < 90);
            if (n_random == 20) begin
                s_tvalid <= 1'b0;
                do @(negedge aclk); while (decoded_q.size() != 0);
            end
            send_token(random_token());
            n_random++;
        end
        calm = 1'b0;

        s_tvalid <= 1'b0;
        do @(negedge aclk); while (decoded_q.size() != 0);
        repeat (TAIL_CYCLES) @(negedge aclk);

        if (mismatches == 0 && decoded_q.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ===== lz_window_copy_decoder.f =====
rtl/core/lzwc_pkg.sv
rtl/core/lzwc_ram.sv
rtl/core/lz_window_copy_decoder.sv
bench/lz_window_copy_decoder_tb.sv
